// File: sv/pps_pkg.sv
// Package with field widths, event codes and table entry types for the process scheduler.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned NAME_W  = 32;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned ARR_W   = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned EVENT_W = 3;

  typedef enum logic [EVENT_W-1:0] {
    EV_CREATED    = 3'd0,
    EV_REJECTED   = 3'd1,
    EV_RAN        = 3'd2,
    EV_RAN_TERM   = 3'd3,
    EV_TERM_UNRUN = 3'd4,
    EV_IDLE       = 3'd5
  } event_e;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    event_e             ev;
    logic [NAME_W-1:0]  name;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    logic [PRIO_W-1:0]  prio;
  } result_t;

endpackage

// File: sv/pps_if.sv
// Request and result channel interfaces of the process scheduler.
`timescale 1ns / 1ps

interface pps_req_if
  import pps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [NAME_W-1:0]  proc_name;
  logic [BURST_W-1:0] burst_time;
  logic [ARR_W-1:0]   arrival_time;
  logic [PRIO_W-1:0]  prio;

  modport source (output valid, kind, proc_name, burst_time, arrival_time, prio,
                  input ready);
  modport sink   (input valid, kind, proc_name, burst_time, arrival_time, prio,
                  output ready);
endinterface

interface pps_res_if
  import pps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [NAME_W-1:0]  out_name;
  logic [BURST_W-1:0] burst_before;
  logic [ARR_W-1:0]   out_arrival;
  logic [PRIO_W-1:0]  out_prio;

  modport source (output valid, event_res, out_name, burst_before, out_arrival, out_prio,
                  input ready);
  modport sink   (input valid, event_res, out_name, burst_before, out_arrival, out_prio,
                  output ready);
endinterface

// File: sv/priority_process_scheduler_unit.sv
// Preemptive priority scheduler: process table in RAM, one shared compare unit scanning it.
// Create: table write happens on acceptance if the table is not full; a full table rejects it.
// Tick: scans the N live entries (one RAM read per cycle through the priority
// compare), then moves each later entry down one slot to close up the table when entry k is removed.
// One request at a time; a new request is taken while the previous result waits at the output.
// Reset clears the live count and the output valid; table contents are not cleared.
`timescale 1ns / 1ps

module priority_process_scheduler_unit
  import pps_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pps_req_if.sink   req_i,
  pps_res_if.source res_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          have_q, have_d;
  logic [IW-1:0] didx_q, didx_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  entry_t        best_q, best_d;
  result_t       res_q, res_d;
  result_t       out_q, out_d;
  logic          out_valid_q, out_valid_d;

  entry_t        mem_q [SLOTS];
  entry_t        rdata_q;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;

  logic          accept;
  logic          out_free;
  logic          last_data;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign last_data   = (CW'(didx_q) == count_q - CW'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    have_d      = 1'b0;
    didx_d      = didx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = ptr_q[IW-1:0];

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.name    = req_i.proc_name;
          res_d.burst   = req_i.burst_time;
          res_d.arrival = req_i.arrival_time;
          res_d.prio    = req_i.prio;
          if (!req_i.kind) begin
            if (count_q == CW'(SLOTS)) begin
              res_d.ev = EV_REJECTED;
            end else begin
              res_d.ev      = EV_CREATED;
              we            = 1'b1;
              waddr         = count_q[IW-1:0];
              wdata.name    = req_i.proc_name;
              wdata.burst   = req_i.burst_time;
              wdata.arrival = req_i.arrival_time;
              wdata.prio    = req_i.prio;
              count_d       = count_q + CW'(1);
            end
            state_d = ST_DONE;
          end else if (count_q == '0) begin
            res_d   = '{ev: EV_IDLE, default: '0};
            state_d = ST_DONE;
          end else begin
            ptr_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the entry read last cycle
        if (ptr_q < count_q) begin
          ptr_d  = ptr_q + CW'(1);
          have_d = 1'b1;
          didx_d = ptr_q[IW-1:0];
        end
        if (have_q) begin
          if (didx_q == '0 || rdata_q.prio > best_q.prio) begin
            best_d     = rdata_q;
            best_idx_d = didx_q;
          end
          if (last_data) begin
            have_d  = 1'b0;
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        res_d.name    = best_q.name;
        res_d.burst   = best_q.burst;
        res_d.arrival = best_q.arrival;
        res_d.prio    = best_q.prio;
        ptr_d         = CW'(best_idx_q) + CW'(1);
        if (best_q.burst == '0) begin
          res_d.ev = EV_TERM_UNRUN;
          state_d  = ST_SHIFT;
        end else if (best_q.burst == BURST_W'(1)) begin
          res_d.ev = EV_RAN_TERM;
          state_d  = ST_SHIFT;
        end else begin
          res_d.ev    = EV_RAN;
          we          = 1'b1;
          waddr       = best_idx_q;
          wdata       = best_q;
          wdata.burst = best_q.burst - BURST_W'(1);
          state_d     = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // move each later entry down one slot
        if (ptr_q < count_q) begin
          ptr_d  = ptr_q + CW'(1);
          have_d = 1'b1;
          didx_d = ptr_q[IW-1:0];
        end
        if (have_q) begin
          we    = 1'b1;
          waddr = didx_q - IW'(1);
          wdata = rdata_q;
        end else if (ptr_q >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    didx_q     <= didx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.event_res    = out_q.ev;
  assign res_o.out_name     = out_q.name;
  assign res_o.burst_before = out_q.burst;
  assign res_o.out_arrival  = out_q.arrival;
  assign res_o.out_prio     = out_q.prio;

endmodule
